FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the page frame replacement block.
// Depends on nothing; simulation builds get checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define LPFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// condition must never be seen outside reset
`define LPFR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define LPFR_ASSERT(lbl, clk, rst_n, prop)
`define LPFR_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/lpfr_pkg.sv
// Types and codes shared by the LRU page frame replacement controller and datapath.
// Depends on nothing.
package lpfr_pkg;

	// result outcome codes
	typedef enum logic [1:0] {
		OUT_HIT    = 2'd0,
		OUT_LOAD   = 2'd1,
		OUT_EVICT  = 2'd2,
		OUT_REJECT = 2'd3
	} outcome_t;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAMES_IN_USE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGE_LIMIT    = 2'd1;

	// access counter and stamp width
	localparam int unsigned STAMP_BITS = 32;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // item accepted: latch page, clear search
		logic scan;      // read the next frame entry
		logic commit;    // apply decision, write entry, advance count
		logic load_out;  // move result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_reject; // page at the input is out of range
		logic last_addr; // read address is the last active frame
		logic out_free;  // output register can take a result now
	} status_t;

endpackage

FILE: hw/rtl/lpfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lpfr_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lpfr_ctrl.sv
// Sequencing state machine of the page frame replacement block.
// Depends on lpfr_pkg (state, command and status types).
module lpfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpfr_pkg::status_t status,
	output lpfr_pkg::cmd_t    cmd
);

	lpfr_pkg::state_t state_q, state_d;
	logic             accept;

	assign accept = in_valid && (state_q == lpfr_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpfr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = status.in_reject ? lpfr_pkg::ST_DONE : lpfr_pkg::ST_SCAN;
				end
			end
			lpfr_pkg::ST_SCAN: begin
				if (status.last_addr) begin
					state_d = lpfr_pkg::ST_DRAIN;
				end
			end
			lpfr_pkg::ST_DRAIN:  state_d = lpfr_pkg::ST_COMMIT;
			lpfr_pkg::ST_COMMIT: state_d = lpfr_pkg::ST_DONE;
			lpfr_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = lpfr_pkg::ST_IDLE;
				end
			end
			default: state_d = lpfr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lpfr_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = accept;
			end
			lpfr_pkg::ST_SCAN:   cmd.scan = 1'b1;
			lpfr_pkg::ST_DRAIN:  ;
			lpfr_pkg::ST_COMMIT: cmd.commit = 1'b1;
			lpfr_pkg::ST_DONE:   cmd.load_out = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/lpfr_datapath.sv
// Datapath: configuration, frame table RAM, valid bits, search accumulators,
// access counter and output register. Depends on lpfr_pkg and lpfr_ram.
module lpfr_datapath #(
	parameter int unsigned FRAMES    = 16,
	parameter int unsigned PAGE_BITS = 16,
	localparam int unsigned AW = $clog2(FRAMES),
	localparam int unsigned FW = AW + 1,
	localparam int unsigned LW = PAGE_BITS + 1,
	localparam int unsigned CW = (FW > LW) ? FW : LW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpfr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CW-1:0]                       cfg_data,
	input  logic [PAGE_BITS-1:0]                page_number,
	input  lpfr_pkg::cmd_t                      cmd,
	output lpfr_pkg::status_t                   status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          outcome,
	output logic [AW-1:0]                       frame_index,
	output logic [PAGE_BITS-1:0]                evicted_page,
	output logic [lpfr_pkg::STAMP_BITS-1:0]     access_stamp
);

	localparam int unsigned SW = lpfr_pkg::STAMP_BITS;
	localparam int unsigned EW = PAGE_BITS + SW;

	// configuration
	logic [FW-1:0] frames_q;
	logic [LW-1:0] limit_q;
	logic [FW-1:0] n_act;

	// item and search state
	logic [PAGE_BITS-1:0] page_q;
	logic [SW-1:0]        count_q;
	logic [FRAMES-1:0]    valid_q;
	logic [AW-1:0]        addr_q;
	logic                 chk_vld_q;
	logic [AW-1:0]        chk_idx_q;
	logic                 hit_found_q, free_found_q;
	logic [AW-1:0]        hit_idx_q, free_idx_q, old_idx_q;
	logic [SW-1:0]        old_age_q;
	logic [PAGE_BITS-1:0] old_page_q;

	// pending result and output register
	logic [1:0]           res_outcome_q, out_outcome_q;
	logic [AW-1:0]        res_frame_q, out_frame_q;
	logic [PAGE_BITS-1:0] res_evict_q, out_evict_q;
	logic [SW-1:0]        res_stamp_q, out_stamp_q;
	logic                 out_valid_q;

	// RAM
	logic [EW-1:0]        rd_entry;
	logic [PAGE_BITS-1:0] rd_page;
	logic [SW-1:0]        rd_stamp;
	logic [SW-1:0]        rd_age;
	logic                 rd_is_valid;

	// commit decision
	lpfr_pkg::outcome_t   dec_outcome;
	logic [AW-1:0]        dec_frame;
	logic [PAGE_BITS-1:0] dec_evict;

	// active frame count, clamped to one..FRAMES
	always_comb begin
		n_act = frames_q;
		if (frames_q == '0) begin
			n_act = FW'(1);
		end else if (frames_q > FW'(FRAMES)) begin
			n_act = FW'(FRAMES);
		end
	end

	assign status.in_reject = {1'b0, page_number} >= limit_q;
	assign status.last_addr = {1'b0, addr_q} == (n_act - FW'(1));
	assign status.out_free  = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FW'(FRAMES);
			limit_q  <= LW'(1) << PAGE_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpfr_pkg::CFG_FRAMES_IN_USE: frames_q <= cfg_data[FW-1:0];
				lpfr_pkg::CFG_PAGE_LIMIT:    limit_q  <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// frame table: page in the upper bits, stamp in the lower
	lpfr_ram #(
		.WIDTH(EW),
		.DEPTH(FRAMES)
	) u_table (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(dec_frame),
		.wdata({page_q, count_q}),
		.re   (cmd.scan),
		.raddr(addr_q),
		.rdata(rd_entry)
	);

	assign rd_page     = rd_entry[EW-1:SW];
	assign rd_stamp    = rd_entry[SW-1:0];
	assign rd_age      = count_q - rd_stamp;
	assign rd_is_valid = valid_q[chk_idx_q];

	// decision from the finished search
	always_comb begin
		if (hit_found_q) begin
			dec_outcome = lpfr_pkg::OUT_HIT;
			dec_frame   = hit_idx_q;
			dec_evict   = '0;
		end else if (free_found_q) begin
			dec_outcome = lpfr_pkg::OUT_LOAD;
			dec_frame   = free_idx_q;
			dec_evict   = '0;
		end else begin
			dec_outcome = lpfr_pkg::OUT_EVICT;
			dec_frame   = old_idx_q;
			dec_evict   = old_page_q;
		end
	end

	// control state: scan address, search flags, valid bits, counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			chk_vld_q    <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			chk_vld_q <= cmd.scan;
			if (cmd.start) begin
				addr_q       <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmd.scan) begin
				addr_q <= addr_q + AW'(1);
			end
			if (chk_vld_q) begin
				if (!hit_found_q && rd_is_valid && rd_page == page_q) begin
					hit_found_q <= 1'b1;
				end
				if (!free_found_q && !rd_is_valid) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				valid_q[dec_frame] <= 1'b1;
				count_q            <= count_q + SW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q        <= page_number;
			res_outcome_q <= lpfr_pkg::OUT_REJECT;
			res_frame_q   <= '0;
			res_evict_q   <= '0;
			res_stamp_q   <= '0;
		end
		if (cmd.scan) begin
			chk_idx_q <= addr_q;
		end
		if (chk_vld_q) begin
			if (!hit_found_q) begin
				hit_idx_q <= chk_idx_q;
			end
			if (!free_found_q) begin
				free_idx_q <= chk_idx_q;
			end
			// oldest entry, ties to the lowest frame
			if (chk_idx_q == '0 || rd_age > old_age_q) begin
				old_age_q  <= rd_age;
				old_idx_q  <= chk_idx_q;
				old_page_q <= rd_page;
			end
		end
		if (cmd.commit) begin
			res_outcome_q <= dec_outcome;
			res_frame_q   <= dec_frame;
			res_evict_q   <= dec_evict;
			res_stamp_q   <= count_q;
		end
		if (cmd.load_out) begin
			out_outcome_q <= res_outcome_q;
			out_frame_q   <= res_frame_q;
			out_evict_q   <= res_evict_q;
			out_stamp_q   <= res_stamp_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = out_outcome_q;
	assign frame_index  = out_frame_q;
	assign evicted_page = out_evict_q;
	assign access_stamp = out_stamp_q;

endmodule

FILE: hw/rtl/lru_page_frame_replacement.sv
// LRU page frame replacement over an inverted page table: top level.
// Depends on lpfr_pkg, lpfr_ctrl, lpfr_datapath and assert_macros.svh.
//
// Input channel (in_valid/in_ready, page_number): one virtual page per item.
// Output channel (out_valid/out_ready): one result per item, giving outcome
// (hit, loaded into free frame, loaded with eviction, rejected), frame_index,
// evicted_page and access_stamp.
// Configuration: cfg_we with cfg_index and cfg_data writes frames_in_use
// (index 0) or virtual_page_limit (index 1); other indexes are ignored.
// Write only while no item is in flight.
// Search: an accepted page is checked against every active frame by reading
// the frame table RAM one entry a cycle (SCAN); the last read then drains
// (DRAIN), the decision is written back (COMMIT) and the result waits for
// the output register (DONE). A rejected page goes straight to DONE. A new
// page is accepted only back in IDLE. The frame table has a single read port.
// The output register holds a finished result while the receiver stalls;
// a new item is accepted meanwhile, but its result waits until the
// register is free.
// Reset clears the valid bits (all frames free), the access count and the
// configuration (all frames active, full page range).
module lru_page_frame_replacement #(
	parameter int unsigned FRAMES    = 16,
	parameter int unsigned PAGE_BITS = 16,
	localparam int unsigned AW = $clog2(FRAMES),
	localparam int unsigned FW = AW + 1,
	localparam int unsigned LW = PAGE_BITS + 1,
	localparam int unsigned CW = (FW > LW) ? FW : LW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpfr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CW-1:0]                       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PAGE_BITS-1:0]                page_number,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          outcome,
	output logic [AW-1:0]                       frame_index,
	output logic [PAGE_BITS-1:0]                evicted_page,
	output logic [lpfr_pkg::STAMP_BITS-1:0]     access_stamp
);

`include "assert_macros.svh"

	lpfr_pkg::cmd_t    cmd;
	lpfr_pkg::status_t status;

	lpfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	lpfr_datapath #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.page_number (page_number),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.outcome     (outcome),
		.frame_index (frame_index),
		.evicted_page(evicted_page),
		.access_stamp(access_stamp)
	);

	// a result is only loaded when the output register can take it
	`LPFR_ASSERT(a_load_when_free, clk, arst_n, cmd.load_out |-> status.out_free)
	// one item at a time: no accept in the cycle after an accept
	`LPFR_ASSERT(a_one_in_flight, clk, arst_n, (in_valid && in_ready) |=> !in_ready)
	// a rejected page never starts a frame scan
	`LPFR_ASSERT(a_reject_no_scan, clk, arst_n,
		(in_valid && in_ready && status.in_reject) |=> !cmd.scan)
	// commands of different phases never coincide
	`LPFR_NEVER(a_cmd_overlap, clk, arst_n, $countones(cmd) > 1)

endmodule
